FILE: sv/wfm_pkg.sv
// ----------------------------------------------------------------------------
// wfm_pkg
// Shared types, constants and the quarter-wave cosine table of the window
// function multiplier.
// ----------------------------------------------------------------------------
package wfm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 12;
    localparam int STEP_W     = 25;
    localparam int KIND_W     = 3;
    localparam int PH_BITS    = 24;
    localparam int QUAD_BITS  = PH_BITS - 2;
    localparam int PFULL_W    = INDEX_W + STEP_W;
    localparam int COS_DEPTH  = 1024;
    localparam int COS_LOG    = $clog2(COS_DEPTH);
    localparam int COS_AW     = COS_LOG + 1;
    localparam int COS_W      = 18;
    localparam int COEF_W     = 18;
    localparam int PROD_W     = COEF_W + COS_W + 1;
    localparam int WIN_W      = 37;
    localparam int MUL_W      = SAMPLE_W + WIN_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = STEP_W;
    localparam int NUM_HARM   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_KIND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 1'd1;
    localparam logic [STEP_W-1:0]    STEP_RESET      = 25'd16400;

    typedef enum logic [KIND_W-1:0] {
        K_PASS      = 3'd0,
        K_BLACKMAN  = 3'd1,
        K_HAMMING   = 3'd2,
        K_HANN      = 3'd3,
        K_TRIANGLE  = 3'd4,
        K_WELCH     = 3'd5,
        K_FLATTOP   = 3'd6,
        K_BHARRIS   = 3'd7
    } t_kind;

    typedef logic signed [COEF_W-1:0] t_coef_row [0:NUM_HARM];
    typedef t_coef_row t_coef_tab [0:7];

    localparam t_coef_tab WIN_COEF = '{
        '{18'sd0,     18'sd0,      18'sd0,     18'sd0,      18'sd0},
        '{18'sd55050, -18'sd65536, 18'sd10486, 18'sd0,      18'sd0},
        '{18'sd71235, -18'sd59837, 18'sd0,     18'sd0,      18'sd0},
        '{18'sd65536, -18'sd65536, 18'sd0,     18'sd0,      18'sd0},
        '{18'sd0,     18'sd0,      18'sd0,     18'sd0,      18'sd0},
        '{18'sd0,     18'sd0,      18'sd0,     18'sd0,      18'sd0},
        '{18'sd28256, -18'sd54609, 18'sd36341, -18'sd10955, 18'sd911},
        '{18'sd47022, -18'sd64001, 18'sd18518, -18'sd1531,  18'sd0}
    };

    typedef logic [COS_AW-1:0] t_addr_vec [0:NUM_HARM-1];

    // Phase stage to window stage
    typedef struct packed {
        logic                      valid;
        logic signed [SAMPLE_W-1:0] sample;
        logic [NUM_HARM-1:0]       neg;
        logic [PH_BITS:0]          at;
    } t_phase_out;

    typedef logic [COS_W-1:0] t_cos_tab [0:COS_DEPTH];

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    typedef longint unsigned t_div_tab [1:10];
    localparam t_div_tab TAYLOR_DIV = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380};

    // Taylor series per entry, evaluated at elaboration
    function automatic t_cos_tab build_cos_tab();
        t_cos_tab        tab;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        for (int k = 0; k <= COS_DEPTH; k++) begin
            x    = longint'(k) * HALF_PI_Q30 / COS_DEPTH;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int n = 1; n <= 10; n++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n];
                if (n % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            tab[k] = COS_W'((longint'(sum) + (64'd1 << 12)) >> 13);
        end
        return tab;
    endfunction

    localparam t_cos_tab COS_TAB = build_cos_tab();

endpackage

FILE: sv/wfm_cos_rom.sv
// ----------------------------------------------------------------------------
// wfm_cos_rom
// Dual-read quarter-wave cosine ROM with registered read data.
// ----------------------------------------------------------------------------
module wfm_cos_rom (
    input  logic                       i_clk,
    input  logic [wfm_pkg::COS_AW-1:0] i_addr_a,
    input  logic [wfm_pkg::COS_AW-1:0] i_addr_b,
    output logic [wfm_pkg::COS_W-1:0]  o_data_a,
    output logic [wfm_pkg::COS_W-1:0]  o_data_b
);
    import wfm_pkg::*;

    logic [COS_W-1:0] r_data_a;
    logic [COS_W-1:0] r_data_b;

    always_ff @(posedge i_clk) begin
        r_data_a <= COS_TAB[i_addr_a];
        r_data_b <= COS_TAB[i_addr_b];
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

FILE: sv/wfm_phase.sv
// ----------------------------------------------------------------------------
// wfm_phase
// Position fraction, per-harmonic table addresses and the folded distance
// from frame center (two register stages).
// ----------------------------------------------------------------------------
module wfm_phase (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [wfm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [wfm_pkg::INDEX_W-1:0]  i_index,
    input  logic [wfm_pkg::STEP_W-1:0]   i_step,
    output wfm_pkg::t_phase_out          o_ph,
    output wfm_pkg::t_addr_vec           o_addr
);
    import wfm_pkg::*;

    logic                       r_v1;
    logic signed [SAMPLE_W-1:0] r_s1;
    logic [PFULL_W-1:0]         r_pfull;
    t_phase_out                 r_ph;
    t_addr_vec                  r_addr;
    t_addr_vec                  n_addr;
    logic [NUM_HARM-1:0]        n_neg;
    logic [PH_BITS:0]           n_at;
    logic [PH_BITS-1:0]         ph;
    logic [PH_BITS-1:0]         hph [0:NUM_HARM-1];
    logic [PFULL_W-1:0]         p;
    logic [PFULL_W:0]           t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_s1    <= i_sample;
        r_pfull <= PFULL_W'(i_index) * PFULL_W'(i_step);
    end

    always_comb begin
        ph     = r_pfull[PH_BITS-1:0];
        hph[0] = ph;
        hph[1] = {ph[PH_BITS-2:0], 1'b0};
        hph[2] = ph + {ph[PH_BITS-2:0], 1'b0};
        hph[3] = {ph[PH_BITS-3:0], 2'b00};
        for (int h = 0; h < NUM_HARM; h++) begin
            logic [1:0]              quad;
            logic [QUAD_BITS-1:0]    r;
            logic [QUAD_BITS+COS_LOG:0] rs;
            logic [COS_AW-1:0]       idx;
            quad = hph[h][PH_BITS-1 -: 2];
            r    = hph[h][QUAD_BITS-1:0];
            rs   = ({(COS_LOG+1)'(0), r} << COS_LOG) + (QUAD_BITS+COS_LOG+1)'(1 << (QUAD_BITS-1));
            idx  = COS_AW'(rs >> QUAD_BITS);
            n_addr[h] = quad[0] ? COS_AW'(COS_DEPTH) - idx : idx;
            n_neg[h]  = quad[0] ^ quad[1];
        end
        // clamp past frame end, then fold around the center
        p    = (r_pfull > PFULL_W'(1 << PH_BITS)) ? PFULL_W'(1 << PH_BITS) : r_pfull;
        t    = {p, 1'b0};
        n_at = (t >= (PFULL_W+1)'(1 << PH_BITS)) ? (PH_BITS+1)'(t - (PFULL_W+1)'(1 << PH_BITS))
                                                 : (PH_BITS+1)'((PFULL_W+1)'(1 << PH_BITS) - t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph.valid <= 1'b0;
        end else begin
            r_ph.valid <= r_v1;
        end
        r_ph.sample <= r_s1;
        r_ph.neg    <= n_neg;
        r_ph.at     <= n_at;
        r_addr      <= n_addr;
    end

    assign o_ph   = r_ph;
    assign o_addr = r_addr;

endmodule

FILE: sv/wfm_window.sv
// ----------------------------------------------------------------------------
// wfm_window
// Window value: cosine lookups, coefficient products and the final sum,
// or the triangle / Welch shape (three register stages).
// ----------------------------------------------------------------------------
module wfm_window (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wfm_pkg::t_kind               i_kind,
    input  wfm_pkg::t_phase_out          i_ph,
    input  wfm_pkg::t_addr_vec           i_addr,
    output logic                         o_valid,
    output logic signed [wfm_pkg::SAMPLE_W-1:0] o_sample,
    output logic signed [wfm_pkg::WIN_W-1:0]    o_win
);
    import wfm_pkg::*;

    logic [COS_W-1:0]           cos_q [0:NUM_HARM-1];
    logic                       r_v3, r_v4, r_v5;
    logic signed [SAMPLE_W-1:0] r_s3, r_s4, r_s5;
    logic [NUM_HARM-1:0]        r_neg3;
    logic [PH_BITS:0]           r_at3;
    logic [2*PH_BITS+1:0]       r_sq3;
    logic signed [PROD_W-1:0]   r_prod4 [0:NUM_HARM-1];
    logic [WIN_W-1:0]           r_lin4;
    logic signed [WIN_W-1:0]    r_win5;
    logic signed [WIN_W-1:0]    n_win;
    logic [2*PH_BITS+1:0]       welch_v;

    wfm_cos_rom u_rom_lo (
        .i_clk    (i_clk),
        .i_addr_a (i_addr[0]),
        .i_addr_b (i_addr[1]),
        .o_data_a (cos_q[0]),
        .o_data_b (cos_q[1])
    );

    wfm_cos_rom u_rom_hi (
        .i_clk    (i_clk),
        .i_addr_a (i_addr[2]),
        .i_addr_b (i_addr[3]),
        .o_data_a (cos_q[2]),
        .o_data_b (cos_q[3])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v3 <= i_ph.valid;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
        r_s3   <= i_ph.sample;
        r_neg3 <= i_ph.neg;
        r_at3  <= i_ph.at;
        r_sq3  <= (2*PH_BITS+2)'(i_ph.at) * (2*PH_BITS+2)'(i_ph.at);
        r_s4   <= r_s3;
        r_s5   <= r_s4;
        r_win5 <= n_win;
    end

    assign welch_v = (2*PH_BITS+2)'(1) << (2*PH_BITS);

    always_ff @(posedge i_clk) begin
        for (int h = 0; h < NUM_HARM; h++) begin
            logic signed [COS_W:0] c;
            c = r_neg3[h] ? -$signed({1'b0, cos_q[h]}) : $signed({1'b0, cos_q[h]});
            r_prod4[h] <= PROD_W'(WIN_COEF[i_kind][h+1]) * PROD_W'(c);
        end
        if (i_kind == K_TRIANGLE) begin
            r_lin4 <= WIN_W'(((PH_BITS+1)'(1 << PH_BITS) - r_at3)) << 10;
        end else begin
            r_lin4 <= WIN_W'((welch_v - r_sq3 + (2*PH_BITS+2)'(1 << 13)) >> 14);
        end
    end

    always_comb begin
        if (i_kind == K_TRIANGLE || i_kind == K_WELCH) begin
            n_win = $signed(r_lin4);
        end else begin
            n_win = (WIN_W'(WIN_COEF[i_kind][0]) <<< 17);
            for (int h = 0; h < NUM_HARM; h++) begin
                n_win = n_win + WIN_W'(r_prod4[h]);
            end
        end
    end

    assign o_valid  = r_v5;
    assign o_sample = r_s5;
    assign o_win    = r_win5;

endmodule

FILE: sv/window_function_multiplier_top.sv
// ----------------------------------------------------------------------------
// window_function_multiplier_top
// Applies the selected window to a stream of Q1.15 samples.
// ----------------------------------------------------------------------------
// One sample is taken every cycle (o_busy stays low) and its result appears
// with o_valid once it has passed the pipeline; the receiver cannot stall,
// so every strobe must be taken when it comes. The pipeline stages are the
// input register, index-times-step multiply, table addressing,
// cosine ROM read, coefficient products, window sum, sample multiply and
// rounding. Write configuration only while no sample is in flight.
module window_function_multiplier_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [wfm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [wfm_pkg::INDEX_W-1:0]  i_sample_index,
    input  logic                         i_cfg_we,
    input  logic [wfm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wfm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                         o_valid,
    output logic signed [wfm_pkg::SAMPLE_W-1:0] o_windowed_sample
);
    import wfm_pkg::*;

    t_kind                      r_kind;
    logic [STEP_W-1:0]          r_step;
    logic                       r_v0, r_v6, r_v7;
    logic signed [SAMPLE_W-1:0] r_s0, r_s6, r_out;
    logic [INDEX_W-1:0]         r_idx0;
    logic signed [MUL_W-1:0]    r_mul6;
    logic signed [MUL_W-1:0]    rnd;
    t_phase_out                 ph;
    t_addr_vec                  addr;
    logic                       w_valid;
    logic signed [SAMPLE_W-1:0] w_sample;
    logic signed [WIN_W-1:0]    w_win;
    logic signed [SAMPLE_W-1:0] n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= K_PASS;
            r_step <= STEP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_WINDOW_KIND: r_kind <= t_kind'(i_cfg_data[KIND_W-1:0]);
                REG_PHASE_STEP:  r_step <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= i_start && !o_busy;
        end
        r_s0   <= i_sample;
        r_idx0 <= i_sample_index;
    end

    wfm_phase u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v0),
        .i_sample (r_s0),
        .i_index  (r_idx0),
        .i_step   (r_step),
        .o_ph     (ph),
        .o_addr   (addr)
    );

    wfm_window u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_kind   (r_kind),
        .i_ph     (ph),
        .i_addr   (addr),
        .o_valid  (w_valid),
        .o_sample (w_sample),
        .o_win    (w_win)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v6 <= w_valid;
            r_v7 <= r_v6;
        end
        r_s6   <= w_sample;
        r_mul6 <= MUL_W'(w_sample) * MUL_W'(w_win);
        r_out  <= n_out;
    end

    // round half up, then saturate; pass mode forwards the sample as is
    always_comb begin
        rnd = (r_mul6 + (MUL_W'(1) <<< 33)) >>> 34;
        if (r_kind == K_PASS) begin
            n_out = r_s6;
        end else if (rnd > MUL_W'(32767)) begin
            n_out = 16'sh7FFF;
        end else if (rnd < -MUL_W'(32768)) begin
            n_out = -16'sh8000;
        end else begin
            n_out = rnd[SAMPLE_W-1:0];
        end
    end

    assign o_valid           = r_v7;
    assign o_windowed_sample = r_out;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives windowed-sample requests into window_function_multiplier_top,
// predicts each result from a private model of the window arithmetic and
// compares every output strobe with the oldest prediction in order.
// ----------------------------------------------------------------------------
module testbench;
    import wfm_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_LIMIT   = 1000;
    localparam longint PH_ONE   = 64'd1 << 24;

    typedef struct {
        bit                         is_cfg;
        logic [CFG_IDX_W-1:0]       reg_sel;
        logic [CFG_DATA_W-1:0]      reg_val;
        logic signed [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]         index;
    } t_request;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_start;
    logic                         o_busy;
    logic signed [SAMPLE_W-1:0]   i_sample;
    logic [INDEX_W-1:0]           i_sample_index;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_index;
    logic [CFG_DATA_W-1:0]        i_cfg_data;
    logic                         o_valid;
    logic signed [SAMPLE_W-1:0]   o_windowed_sample;

    t_request                   pending_reqs[$];
    logic signed [SAMPLE_W-1:0] expected_samples[$];
    longint                     cos_rom[0:COS_DEPTH];
    longint                     shape_coef[0:7][0:4];
    t_kind                      cur_kind = K_PASS;
    logic [STEP_W-1:0]          cur_step = STEP_RESET;
    int                         mismatches = 0;
    int                         quiet_cycles;
    int                         idle_cycles = 0;
    int                         gap_left;
    bit                         no_gaps;

    window_function_multiplier_top dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint cos_lookup(longint unsigned ph);
        longint unsigned a;
        longint unsigned r;
        longint unsigned ix;
        a  = ph & (PH_ONE - 1);
        r  = a & ((64'd1 << 22) - 1);
        ix = (r * COS_DEPTH + (64'd1 << 21)) >> 22;
        case (a >> 22)
            0: return cos_rom[ix];
            1: return -cos_rom[COS_DEPTH - ix];
            2: return -cos_rom[ix];
            default: return cos_rom[COS_DEPTH - ix];
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] window_product(
        t_kind kind, logic [STEP_W-1:0] step,
        logic signed [SAMPLE_W-1:0] smp, logic [INDEX_W-1:0] ix);
        longint unsigned pfull;
        longint unsigned p;
        longint          t;
        longint          w;
        longint          res;
        pfull = longint'(ix) * longint'(step);
        if (kind == K_PASS) return smp;
        if (kind == K_TRIANGLE || kind == K_WELCH) begin
            p = (pfull > PH_ONE) ? PH_ONE : pfull;
            t = 2 * longint'(p) - PH_ONE;
            if (t < 0) t = -t;
            if (kind == K_TRIANGLE) w = (PH_ONE - t) <<< 10;
            else w = (PH_ONE * PH_ONE - t * t + (64'sd1 << 13)) >>> 14;
        end else begin
            w = shape_coef[kind][0] * 131072;
            for (int h = 1; h <= 4; h++)
                w += shape_coef[kind][h] * cos_lookup(h * (pfull & (PH_ONE - 1)));
        end
        res = (longint'(smp) * w + (64'sd1 << 33)) >>> 34;
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        return SAMPLE_W'(res);
    endfunction

    function automatic t_request cfg_req(logic [CFG_IDX_W-1:0] sel, longint val);
        t_request r;
        r = '{1'b1, sel, CFG_DATA_W'(val), '0, '0};
        return r;
    endfunction

    function automatic t_request sample_req(longint smp, longint ix);
        t_request r;
        r = '{1'b0, '0, '0, SAMPLE_W'(smp), INDEX_W'(ix)};
        return r;
    endfunction

    function automatic longint pick_step();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 64'd1 << 24;
            3: return (64'd1 << 25) - 1;
            4: return $urandom_range(1, (1 << 25) - 1);
            default: return (64'd1 << 24) / $urandom_range(1, 4095);
        endcase
    endfunction

    // Quarter-wave cosine, Taylor series in Q30, rounded to Q17
    initial begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        for (int k = 0; k <= COS_DEPTH; k++) begin
            x    = longint'(k) * 64'd1686629713 / COS_DEPTH;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int n = 1; n <= 10; n++) begin
                term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
                sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            cos_rom[k] = (sum + (64'sd1 << 12)) >>> 13;
        end
        shape_coef = '{'{0, 0, 0, 0, 0}, '{55050, -65536, 10486, 0, 0},
                       '{71235, -59837, 0, 0, 0}, '{65536, -65536, 0, 0, 0},
                       '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0},
                       '{28256, -54609, 36341, -10955, 911},
                       '{47022, -64001, 18518, -1531, 0}};
    end

    // Request list, then wait for the pipeline to drain
    initial begin
        int n_phase;
        i_clk    = 1'b0;
        i_rst_n  = 1'b0;
        // directed: every window shape with extreme samples and positions
        for (int k = K_PASS; k <= K_BHARRIS; k++) begin
            pending_reqs.push_back(cfg_req(REG_WINDOW_KIND, k));
            pending_reqs.push_back(cfg_req(REG_PHASE_STEP, (k == K_WELCH) ? 0 :
                                   (k == K_TRIANGLE) ? (1 << 25) - 1 : 16400));
            pending_reqs.push_back(sample_req(-32768, 0));
            pending_reqs.push_back(sample_req(32767, 4095));
            pending_reqs.push_back(sample_req(-1, 1023));
        end
        n_phase = 0;
        while (n_phase < 20) begin
            pending_reqs.push_back(cfg_req(REG_WINDOW_KIND, $urandom_range(0, 7)));
            pending_reqs.push_back(cfg_req(REG_PHASE_STEP, pick_step()));
            repeat (30) begin
                case ($urandom_range(0, 9))
                    0: pending_reqs.push_back(sample_req($urandom_range(0, 1) ? 32767 : -32768,
                                                         $urandom_range(0, 4095)));
                    1: pending_reqs.push_back(sample_req($urandom, $urandom_range(0, 1) * 4095));
                    default: pending_reqs.push_back(sample_req($urandom, $urandom));
                endcase
            end
            n_phase++;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0);
        do @(posedge i_clk); while (i_start || expected_samples.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Driver: one request per accepted start, config only when idle
    always @(posedge i_clk) begin
        t_request req;
        logic     nxt_start;
        logic     nxt_we;
        if (!i_rst_n) begin
            i_start        <= 1'b0;
            i_sample       <= '0;
            i_sample_index <= '0;
            i_cfg_we       <= 1'b0;
            i_cfg_index    <= '0;
            i_cfg_data     <= '0;
            gap_left       = 0;
            quiet_cycles   = 0;
            no_gaps        = 1'b0;
        end else if (!(i_start && o_busy)) begin
            nxt_start = 1'b0;
            nxt_we    = 1'b0;
            if (i_start) begin
                expected_samples.push_back(window_product(cur_kind, cur_step,
                                                          i_sample, i_sample_index));
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() != 0) begin
                req = pending_reqs[0];
                if (req.is_cfg) begin
                    // hold until nothing is in flight
                    if (!i_start && expected_samples.size() == 0 &&
                        quiet_cycles >= DRAIN_CYCLES) begin
                        void'(pending_reqs.pop_front());
                        nxt_we = 1'b1;
                        i_cfg_index <= req.reg_sel;
                        i_cfg_data  <= req.reg_val;
                        if (req.reg_sel == REG_WINDOW_KIND)
                            cur_kind = t_kind'(req.reg_val[KIND_W-1:0]);
                        else cur_step = req.reg_val;
                    end
                end else begin
                    void'(pending_reqs.pop_front());
                    nxt_start = 1'b1;
                    i_sample       <= req.sample;
                    i_sample_index <= req.index;
                    if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
                    gap_left = no_gaps ? 0 : $urandom_range(0, 8);
                end
            end
            i_start  <= nxt_start;
            i_cfg_we <= nxt_we;
        end
    end

    // Monitor: every strobe must match the oldest prediction
    always @(posedge i_clk) begin
        logic signed [SAMPLE_W-1:0] want;
        if (i_rst_n && o_valid) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d",
                         $realtime, o_windowed_sample);
                mismatches++;
            end else begin
                want = expected_samples.pop_front();
                if (o_windowed_sample !== want) begin
                    $display("%0t: windowed_sample expected %0d, actual %0d",
                             $realtime, want, o_windowed_sample);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
